[design/tpa_pkg.sv]
// Package for the triangle primitive assembler: action, mode and status codes,
// handle width and the result entry type. It has no dependencies.
package tpa_pkg;

    // Stored handle width; the result ports stay 16 bits wide.
    localparam int HANDLE_BITS = 16;
    localparam int OUT_BITS    = 16;
    localparam int SLOT_BITS   = (HANDLE_BITS < OUT_BITS) ? HANDLE_BITS : OUT_BITS;

    // Depth of the result queue and its index width.
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_BEGIN  = 2'd0,
        ACT_VERTEX = 2'd1,
        ACT_END    = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        MODE_TRIANGLES = 3'd0,
        MODE_QUADS     = 3'd1,
        MODE_FAN       = 3'd2,
        MODE_STRIP     = 3'd3,
        MODE_POLYGON   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_TRIANGLE = 2'd0,
        STATUS_ACCEPTED = 2'd1,
        STATUS_BAD_OP   = 2'd2,
        STATUS_BAD_MODE = 2'd3
    } status_t;

    typedef logic [SLOT_BITS-1:0] handle_t;

    // One result item as it waits in the queue.
    typedef struct packed {
        logic [OUT_BITS-1:0] v0;
        logic [OUT_BITS-1:0] v1;
        logic [OUT_BITS-1:0] v2;
        status_t             status;
        logic                last;
    } result_t;

endpackage

[design/triangle_primitive_assembler_top.sv]
// Triangle primitive assembler: batch state, triangle assembly and result queue.
// Depends on tpa_pkg.
//
// Usage:
//   The input channel (in_valid/in_ready) carries begin, vertex and end items.
//   A begin item opens a batch in triangles, quads, fan, strip or polygon mode
//   and answers with a status result; vertex items inside a batch produce
//   triangles of handles as they complete; an end item closes the batch and
//   answers with a status result. Vertices outside a batch cause no result.
//   The output channel (out_valid/out_ready) carries one result item per
//   handshake; last marks the final result caused by one input item.
//   Throughput: one item per cycle while in_ready is high. Each item is
//   decoded in the cycle it is accepted and its results (at most two, for a
//   quad) are written into a four-entry result queue. in_ready is high while
//   at most two results are queued, so a quad never overflows the queue.
//   When the receiver stalls, results collect in the queue and in_ready drops
//   once three are waiting; nothing is lost or repeated.
//   Reset: the batch is closed, counters clear and the queue is empty. The
//   held vertex slots are not reset; they are always written before use.
module triangle_primitive_assembler_top
    import tpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [2:0]  draw_mode,
    input  logic [15:0] vertex_handle,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] first_vertex,
    output logic [15:0] second_vertex,
    output logic [15:0] third_vertex,
    output logic [1:0]  status,
    output logic        last
);

    // Batch state.
    logic                batch_open_reg, batch_open_next;
    mode_t               mode_reg, mode_next;
    logic [1:0]          phase_reg, phase_next;
    logic [1:0]          have_reg, have_next;
    handle_t             slot_a_reg, slot_a_next;
    handle_t             slot_b_reg, slot_b_next;
    handle_t             slot_c_reg, slot_c_next;

    // Result queue.
    result_t             queue_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;

    logic                accept;
    logic                pop;
    logic [1:0]          n_push;
    result_t             res0, res1;
    handle_t             v_in;
    result_t             head;

    assign accept = in_valid && in_ready;
    assign pop    = out_valid && out_ready;
    assign v_in   = SLOT_BITS'(vertex_handle);

    // Decode the accepted item: next batch state and the results it causes.
    always_comb
    begin
        batch_open_next = batch_open_reg;
        mode_next       = mode_reg;
        phase_next      = phase_reg;
        have_next       = have_reg;
        slot_a_next     = slot_a_reg;
        slot_b_next     = slot_b_reg;
        slot_c_next     = slot_c_reg;
        n_push          = 2'd0;
        res0            = '{v0: '0, v1: '0, v2: '0, status: STATUS_ACCEPTED, last: 1'b1};
        res1            = '{v0: '0, v1: '0, v2: '0, status: STATUS_TRIANGLE, last: 1'b1};
        if (accept)
        begin
            case (action_t'(action))
                ACT_BEGIN:
                begin
                    n_push = 2'd1;
                    if (batch_open_reg)
                    begin
                        res0.status = STATUS_BAD_OP;
                    end
                    else if (draw_mode inside {[3'd0:3'd4]})
                    begin
                        batch_open_next = 1'b1;
                        mode_next       = mode_t'(draw_mode);
                        phase_next      = 2'd0;
                        have_next       = 2'd0;
                    end
                    else
                    begin
                        res0.status = STATUS_BAD_MODE;
                    end
                end
                ACT_VERTEX:
                begin
                    if (batch_open_reg)
                    begin
                        res0.status = STATUS_TRIANGLE;
                        case (mode_reg)
                            MODE_TRIANGLES:
                            begin
                                if (phase_reg == 2'd0)
                                begin
                                    slot_a_next = v_in;
                                    phase_next  = 2'd1;
                                end
                                else if (phase_reg == 2'd1)
                                begin
                                    slot_b_next = v_in;
                                    phase_next  = 2'd2;
                                end
                                else
                                begin
                                    phase_next = 2'd0;
                                    n_push     = 2'd1;
                                    res0.v0    = OUT_BITS'(slot_a_reg);
                                    res0.v1    = OUT_BITS'(slot_b_reg);
                                    res0.v2    = OUT_BITS'(v_in);
                                end
                            end
                            MODE_QUADS:
                            begin
                                if (phase_reg == 2'd0)
                                begin
                                    slot_a_next = v_in;
                                    phase_next  = 2'd1;
                                end
                                else if (phase_reg == 2'd1)
                                begin
                                    slot_b_next = v_in;
                                    phase_next  = 2'd2;
                                end
                                else if (phase_reg == 2'd2)
                                begin
                                    slot_c_next = v_in;
                                    phase_next  = 2'd3;
                                end
                                else
                                begin
                                    // Second triangle of the quad closes back on its first vertex.
                                    phase_next = 2'd0;
                                    n_push     = 2'd2;
                                    res0.v0    = OUT_BITS'(slot_a_reg);
                                    res0.v1    = OUT_BITS'(slot_b_reg);
                                    res0.v2    = OUT_BITS'(slot_c_reg);
                                    res0.last  = 1'b0;
                                    res1.v0    = OUT_BITS'(slot_c_reg);
                                    res1.v1    = OUT_BITS'(v_in);
                                    res1.v2    = OUT_BITS'(slot_a_reg);
                                end
                            end
                            MODE_FAN, MODE_STRIP:
                            begin
                                if (have_reg == 2'd0)
                                begin
                                    slot_a_next = v_in;
                                    have_next   = 2'd1;
                                end
                                else if (have_reg == 2'd1)
                                begin
                                    slot_b_next = v_in;
                                    have_next   = 2'd2;
                                end
                                else
                                begin
                                    n_push  = 2'd1;
                                    res0.v0 = OUT_BITS'(slot_a_reg);
                                    res0.v1 = OUT_BITS'(slot_b_reg);
                                    res0.v2 = OUT_BITS'(v_in);
                                    slot_b_next = v_in;
                                    // A strip slides its window; a fan keeps its root.
                                    if (mode_reg == MODE_STRIP)
                                    begin
                                        slot_a_next = slot_b_reg;
                                    end
                                end
                            end
                            default:
                            begin
                                n_push = 2'd0;
                            end
                        endcase
                    end
                end
                ACT_END:
                begin
                    n_push = 2'd1;
                    if (!batch_open_reg)
                    begin
                        res0.status = STATUS_BAD_OP;
                    end
                    else
                    begin
                        batch_open_next = 1'b0;
                        phase_next      = 2'd0;
                        have_next       = 2'd0;
                        if (mode_reg == MODE_POLYGON)
                        begin
                            res0.status = STATUS_BAD_MODE;
                        end
                    end
                end
                default:
                begin
                    n_push = 2'd0;
                end
            endcase
        end
    end

    // Batch control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_open_reg <= 1'b0;
            mode_reg       <= MODE_TRIANGLES;
            phase_reg      <= 2'd0;
            have_reg       <= 2'd0;
        end
        else
        begin
            batch_open_reg <= batch_open_next;
            mode_reg       <= mode_next;
            phase_reg      <= phase_next;
            have_reg       <= have_next;
        end
    end

    // Held vertex handles carry no reset.
    always_ff @(posedge clk)
    begin
        slot_a_reg <= slot_a_next;
        slot_b_reg <= slot_b_next;
        slot_c_reg <= slot_c_next;
    end

    // Result queue storage.
    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (n_push == 2'd2)
        begin
            queue_reg[wr_ptr_reg + PTR_BITS'(1)] <= res1;
        end
    end

    // Result queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(n_push);
            rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(pop);
            count_reg  <= count_reg + CNT_BITS'(n_push) - CNT_BITS'(pop);
        end
    end

    // Room for a quad's two results is always kept before an item is taken.
    assign in_ready  = (count_reg <= CNT_BITS'(QUEUE_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign head      = queue_reg[rd_ptr_reg];

    assign first_vertex  = head.v0;
    assign second_vertex = head.v1;
    assign third_vertex  = head.v2;
    assign status        = head.status;
    assign last          = head.last;

    // The queue never holds more entries than it has.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(QUEUE_DEPTH))
        else $error("result queue overflow");

    // The first triangle of a quad is always followed by its partner in the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> count_reg >= CNT_BITS'(2))
        else $error("quad triangle without its partner");

    // Status results carry zero handles.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_TRIANGLE |->
            first_vertex == '0 && second_vertex == '0 && third_vertex == '0)
        else $error("status result with nonzero handles");

    // A closed batch holds no partial group.
    assert property (@(posedge clk) disable iff (!rst_n)
        !batch_open_reg |-> phase_reg == 2'd0 && have_reg == 2'd0)
        else $error("partial group outside a batch");

    // The fan and strip count saturates at two.
    assert property (@(posedge clk) disable iff (!rst_n)
        have_reg <= 2'd2)
        else $error("vertex count beyond two");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the triangle primitive assembler: directed and random
// begin/vertex/end items, a built-in triangle predictor and random stalls on both sides.
// Depends on tpa_pkg and triangle_primitive_assembler_top.
module tb_top;
    import tpa_pkg::*;

    // Action code that the block does not decode.
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    // Largest code the draw_mode field can carry.
    localparam int MODE_CODE_MAX = 7;
    localparam int RANDOM_ITEMS  = 1650;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 10;

    // One input item waiting to be driven, with the pause the sender takes after it.
    typedef struct {
        logic [1:0]  act;
        logic [2:0]  mode;
        logic [15:0] handle;
        int          gap;
        bit          drain;
    } stim_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  action = ACT_BEGIN;
    logic [2:0]  draw_mode = MODE_TRIANGLES;
    logic [15:0] vertex_handle = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] first_vertex;
    logic [15:0] second_vertex;
    logic [15:0] third_vertex;
    logic [1:0]  status;
    logic        last;

    stim_t   stim_q[$];
    result_t triangle_q[$];
    int      exp_count = 0;
    int      got_count = 0;
    int      errors = 0;
    int      cycles = 0;

    // Generator state.
    int gen_count = 0;
    bit gen_quiet = 1'b0;
    bit gen_drain_next = 1'b0;

    // Predictor copy of the batch state.
    bit          pr_open = 1'b0;
    logic [2:0]  pr_mode = MODE_TRIANGLES;
    logic [1:0]  pr_phase = '0;
    logic [1:0]  pr_held = '0;
    handle_t     pr_a = '0;
    handle_t     pr_b = '0;
    handle_t     pr_c = '0;

    triangle_primitive_assembler_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .draw_mode     (draw_mode),
        .vertex_handle (vertex_handle),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .first_vertex  (first_vertex),
        .second_vertex (second_vertex),
        .third_vertex  (third_vertex),
        .status        (status),
        .last          (last)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Queue one expected result.
    function automatic void push_triangle(handle_t v0, handle_t v1, handle_t v2,
                                          status_t st, logic lst);
        result_t r;
        r.v0     = 16'(v0);
        r.v1     = 16'(v1);
        r.v2     = 16'(v2);
        r.status = st;
        r.last   = lst;
        triangle_q.push_back(r);
        exp_count++;
    endfunction

    // Work out the results of one accepted item and advance the batch state.
    function automatic void assemble_item(stim_t it);
        handle_t v;
        v = handle_t'(it.handle);
        case (it.act)
            ACT_BEGIN:
            begin
                if (pr_open)
                    push_triangle('0, '0, '0, STATUS_BAD_OP, 1'b1);
                else if (it.mode > MODE_POLYGON)
                    push_triangle('0, '0, '0, STATUS_BAD_MODE, 1'b1);
                else
                begin
                    pr_open  = 1'b1;
                    pr_mode  = it.mode;
                    pr_phase = '0;
                    pr_held  = '0;
                    push_triangle('0, '0, '0, STATUS_ACCEPTED, 1'b1);
                end
            end
            ACT_VERTEX:
            begin
                if (pr_open)
                begin
                    case (pr_mode)
                        MODE_TRIANGLES:
                        begin
                            if (pr_phase == 0)
                            begin
                                pr_a = v;
                                pr_phase = 1;
                            end
                            else if (pr_phase == 1)
                            begin
                                pr_b = v;
                                pr_phase = 2;
                            end
                            else
                            begin
                                pr_phase = 0;
                                push_triangle(pr_a, pr_b, v, STATUS_TRIANGLE, 1'b1);
                            end
                        end
                        MODE_QUADS:
                        begin
                            if (pr_phase == 0)
                                pr_a = v;
                            else if (pr_phase == 1)
                                pr_b = v;
                            else if (pr_phase == 2)
                                pr_c = v;
                            else
                            begin
                                push_triangle(pr_a, pr_b, pr_c, STATUS_TRIANGLE, 1'b0);
                                push_triangle(pr_c, v, pr_a, STATUS_TRIANGLE, 1'b1);
                            end
                            pr_phase = pr_phase + 2'd1;
                        end
                        MODE_FAN, MODE_STRIP:
                        begin
                            if (pr_held == 0)
                            begin
                                pr_a = v;
                                pr_held = 1;
                            end
                            else if (pr_held == 1)
                            begin
                                pr_b = v;
                                pr_held = 2;
                            end
                            else
                            begin
                                push_triangle(pr_a, pr_b, v, STATUS_TRIANGLE, 1'b1);
                                // A strip slides its window; a fan keeps its root.
                                if (pr_mode == MODE_STRIP)
                                    pr_a = pr_b;
                                pr_b = v;
                            end
                        end
                        default:
                        begin
                            // Polygon vertices are taken without a result.
                        end
                    endcase
                end
            end
            ACT_END:
            begin
                if (!pr_open)
                    push_triangle('0, '0, '0, STATUS_BAD_OP, 1'b1);
                else
                begin
                    pr_open  = 1'b0;
                    pr_phase = '0;
                    pr_held  = '0;
                    push_triangle('0, '0, '0,
                                  (pr_mode == MODE_POLYGON) ? STATUS_BAD_MODE
                                                            : STATUS_ACCEPTED, 1'b1);
                end
            end
            default:
            begin
                // The unused action code is dropped.
            end
        endcase
    endfunction

    // Append one item; counted items are those the block does something with.
    task automatic add_item(logic [1:0] act, logic [2:0] mode, logic [15:0] handle,
                            bit counted);
        stim_t it;
        it.act    = act;
        it.mode   = mode;
        it.handle = handle;
        it.gap    = gen_quiet ? 0 : $urandom_range(0, 3);
        it.drain  = gen_drain_next;
        gen_drain_next = 1'b0;
        stim_q.push_back(it);
        if (counted)
            gen_count++;
    endtask

    function automatic logic [15:0] pick_handle();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [2:0] any_mode();
        return 3'($urandom_range(0, MODE_CODE_MAX));
    endfunction

    // An item that hits the block outside a batch.
    task automatic add_stray();
        case ($urandom_range(0, 3))
            0: add_item(ACT_END, any_mode(), pick_handle(), 1'b1);
            1: add_item(ACT_VERTEX, any_mode(), pick_handle(), 1'b0);
            2: add_item(ACT_BEGIN, 3'($urandom_range(int'(MODE_POLYGON) + 1, MODE_CODE_MAX)),
                        pick_handle(), 1'b1);
            default: add_item(ACT_UNUSED, any_mode(), pick_handle(), 1'b0);
        endcase
    endtask

    // Directed part: error cases, extreme handles and one batch per mode.
    task automatic add_directed();
        add_item(ACT_END, MODE_TRIANGLES, '0, 1'b1);
        add_item(ACT_VERTEX, MODE_TRIANGLES, '1, 1'b0);
        add_item(ACT_UNUSED, 3'(MODE_CODE_MAX), '1, 1'b0);
        add_item(ACT_BEGIN, 3'(MODE_CODE_MAX), '0, 1'b1);
        // Triangles with extreme handles, a second begin and a dropped partial group.
        add_item(ACT_BEGIN, MODE_TRIANGLES, '0, 1'b1);
        add_item(ACT_BEGIN, 3'(int'(MODE_POLYGON) + 1), '0, 1'b1);
        add_item(ACT_VERTEX, any_mode(), 16'h0000, 1'b1);
        add_item(ACT_VERTEX, any_mode(), 16'hFFFF, 1'b1);
        add_item(ACT_VERTEX, any_mode(), 16'hAAAA, 1'b1);
        add_item(ACT_VERTEX, any_mode(), 16'h5555, 1'b1);
        add_item(ACT_END, any_mode(), '1, 1'b1);
        // One full quad.
        add_item(ACT_BEGIN, MODE_QUADS, '0, 1'b1);
        for (int i = 0; i < 4; i++)
            add_item(ACT_VERTEX, any_mode(), pick_handle(), 1'b1);
        add_item(ACT_END, any_mode(), '0, 1'b1);
        // A fan too short to make a triangle.
        add_item(ACT_BEGIN, MODE_FAN, '0, 1'b1);
        add_item(ACT_VERTEX, any_mode(), pick_handle(), 1'b1);
        add_item(ACT_END, any_mode(), '0, 1'b1);
        // A strip with one triangle.
        add_item(ACT_BEGIN, MODE_STRIP, '0, 1'b1);
        for (int i = 0; i < 3; i++)
            add_item(ACT_VERTEX, any_mode(), pick_handle(), 1'b1);
        add_item(ACT_END, any_mode(), '0, 1'b1);
        // Polygon batches close with a mode error.
        add_item(ACT_BEGIN, MODE_POLYGON, '0, 1'b1);
        add_item(ACT_VERTEX, any_mode(), pick_handle(), 1'b1);
        add_item(ACT_END, any_mode(), '0, 1'b1);
    endtask

    // Random part: mostly well-formed batches, with stray and broken items mixed in.
    task automatic add_random();
        int target;
        int nverts;
        target = gen_count + RANDOM_ITEMS;
        gen_drain_next = 1'b1;
        while (gen_count < target)
        begin
            if ($urandom_range(0, 15) == 0)
                gen_quiet = !gen_quiet;
            if ($urandom_range(0, 39) == 0)
                gen_drain_next = 1'b1;
            if ($urandom_range(0, 9) == 0)
                add_stray();
            else
            begin
                add_item(ACT_BEGIN, 3'($urandom_range(0, int'(MODE_POLYGON))),
                         pick_handle(), 1'b1);
                nverts = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24)
                                                     : $urandom_range(0, 9);
                for (int i = 0; i < nverts; i++)
                begin
                    // Occasionally a second begin or an unused code lands mid-batch.
                    if ($urandom_range(0, 19) == 0)
                    begin
                        if ($urandom_range(0, 1) == 0)
                            add_item(ACT_BEGIN, any_mode(), pick_handle(), 1'b1);
                        else
                            add_item(ACT_UNUSED, any_mode(), pick_handle(), 1'b0);
                    end
                    add_item(ACT_VERTEX, any_mode(), pick_handle(), 1'b1);
                end
                add_item(ACT_END, any_mode(), pick_handle(), 1'b1);
            end
        end
    endtask

    // Sender: one item at a time from stim_q, with a drawn pause after each.
    int    drv_gap = 0;
    bit    drv_on;
    stim_t drv_cur;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            drv_on = in_valid;
            if (in_valid && in_ready)
            begin
                assemble_item(drv_cur);
                drv_gap = drv_cur.gap;
                drv_on = 1'b0;
            end
            if (!drv_on)
            begin
                if (drv_gap > 0)
                    drv_gap--;
                else if (stim_q.size() > 0 && !(stim_q[0].drain && got_count != exp_count))
                begin
                    drv_cur = stim_q.pop_front();
                    action        <= drv_cur.act;
                    draw_mode     <= drv_cur.mode;
                    vertex_handle <= drv_cur.handle;
                    drv_on = 1'b1;
                end
            end
            in_valid <= drv_on;
        end
    end

    task automatic report_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Receiver: compares each result item with the oldest expectation, stalls at random.
    int      rcv_stall = 0;
    bit      rcv_quiet = 1'b0;
    bit      rcv_ready;
    result_t rcv_want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rcv_ready = out_ready;
            if (out_valid && out_ready)
            begin
                if (triangle_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h %h %h %h %b",
                             $time, first_vertex, second_vertex, third_vertex, status, last);
                    errors++;
                end
                else
                begin
                    rcv_want = triangle_q.pop_front();
                    report_field("first_vertex", rcv_want.v0, first_vertex);
                    report_field("second_vertex", rcv_want.v1, second_vertex);
                    report_field("third_vertex", rcv_want.v2, third_vertex);
                    report_field("status", 16'(rcv_want.status), 16'(status));
                    report_field("last", 16'(rcv_want.last), 16'(last));
                end
                got_count <= got_count + 1;
                if ($urandom_range(0, 23) == 0)
                    rcv_quiet = !rcv_quiet;
                rcv_stall = rcv_quiet ? 0 : $urandom_range(0, 3);
                rcv_ready = (rcv_stall == 0);
            end
            else if (!out_ready)
            begin
                if (rcv_stall > 0)
                    rcv_stall--;
                if (rcv_stall == 0)
                    rcv_ready = 1'b1;
            end
            out_ready <= rcv_ready;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Build the stimulus, then wait for every item and every result to go through.
    initial
    begin
        add_directed();
        add_random();
        @(posedge clk);
        // The sender's own flag covers the edge at which the last item is taken from the queue.
        while (!rst_n || stim_q.size() != 0 || drv_on || in_valid)
            @(posedge clk);
        while (got_count != exp_count)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (triangle_q.size() != 0)
        begin
            $display("%0t: %0d results expected but never seen", $time, triangle_q.size());
            errors++;
        end
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[triangle_primitive_assembler_top.f]
design/tpa_pkg.sv
design/triangle_primitive_assembler_top.sv
dv/tb_top.sv
